### rtl/renc_pkg.sv
// ----------------------------------------------------------------------------
// renc_pkg: shared types and constants for the rotary encoder block
// Payload structs, event codes and the quadrature step table.
// ----------------------------------------------------------------------------
package renc_pkg;

	// Event codes reported with every result.
	typedef enum logic [2:0] {
		EV_NONE        = 3'd0,
		EV_CW          = 3'd1,
		EV_CCW         = 3'd2,
		EV_CW_PRESSED  = 3'd3,
		EV_CCW_PRESSED = 3'd4,
		EV_CLICK       = 3'd5
	} event_t;

	// Input kinds.
	localparam logic KIND_ROT = 1'b0;
	localparam logic KIND_SW  = 1'b1;

	localparam int unsigned DEBOUNCE_W = 16;
	localparam int unsigned TIME_W     = 32;

	typedef logic [DEBOUNCE_W-1:0] debounce_t;
	typedef logic [TIME_W-1:0]     time_t;
	typedef logic signed [1:0]     step_t;

	localparam debounce_t DEBOUNCE_RESET = 16'd10;
	localparam logic [1:0] AB_RESET      = 2'b11;

	typedef struct packed {
		logic  kind;
		logic  level_a;
		logic  level_b;
		logic  level_sw;
		time_t now_ms;
	} item_t;

	typedef struct packed {
		event_t event_res;
		logic   button_pressed;
	} result_t;

	// Rotation status from the quadrature decoder.
	typedef struct packed {
		logic cw;
		logic ccw;
	} rot_stat_t;

	// Button status from the debouncer.
	typedef struct packed {
		logic accept;
		logic level;
	} btn_stat_t;

	// Step for each {previous AB, current AB} transition; index 0 is the
	// leftmost entry of the list below.
	localparam step_t QUAD_STEP [16] = '{
		2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd1, 2'sd0, 2'sd0, -2'sd1,
		-2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0
	};

endpackage

### rtl/renc_chan_if.sv
// ----------------------------------------------------------------------------
// renc_chan_if: valid/ready channel
// Carries one payload of type T per transaction.
// ----------------------------------------------------------------------------
interface renc_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/rotary_encoder_with_button.sv
// ----------------------------------------------------------------------------
// rotary_encoder_with_button: rotary encoder and push button event decoder
// Each accepted item waits in the input register; its result is registered
// in the result register. Throughput: one item per cycle unless the result
// channel stalls; the state update for an item completes in the same cycle
// it leaves the input register, so the next item sees it.
// Reset: arst_n clears the pipeline and sets AB history to 11, accumulator
// to 0, button released, last change time 0 and debounce interval 10 ms.
// ----------------------------------------------------------------------------
module rotary_encoder_with_button (
	input  logic        clk,
	input  logic        arst_n,
	renc_chan_if.sink   item,
	renc_chan_if.sink   cfg,
	renc_chan_if.source result
);

	// Input register stage.
	logic             valid_s1;
	renc_pkg::item_t  item_s1;

	// Result register.
	logic             out_valid_q;
	renc_pkg::result_t out_q;

	// The item in stage 1 moves on when the result register is free or is
	// being emptied in this same cycle.
	logic adv;
	logic rot_en;
	logic btn_en;

	renc_pkg::rot_stat_t rot;
	renc_pkg::btn_stat_t btn;

	logic             rotated_q;
	renc_pkg::event_t ev;
	logic             pressed_next;

	assign adv    = valid_s1 && (!out_valid_q || result.ready);
	assign rot_en = adv && (item_s1.kind == renc_pkg::KIND_ROT);
	assign btn_en = adv && (item_s1.kind == renc_pkg::KIND_SW);

	// Stage 1 accepts a new transaction whenever it is empty or draining.
	assign item.ready = !valid_s1 || adv;

	// The configuration register can be written at any time.
	assign cfg.ready = 1'b1;

	renc_rot u_rot (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (rot_en),
		.level_a (item_s1.level_a),
		.level_b (item_s1.level_b),
		.stat    (rot)
	);

	renc_btn u_btn (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg.valid),
		.cfg_data (cfg.data),
		.en       (btn_en),
		.level_sw (item_s1.level_sw),
		.now_ms   (item_s1.now_ms),
		.stat     (btn)
	);

	// Event selection. A detent is marked as pressed when the debounced
	// switch is low. A release counts as a click only if no detent was
	// seen since the matching press.
	always_comb begin
		ev           = renc_pkg::EV_NONE;
		pressed_next = !btn.level;
		if (item_s1.kind == renc_pkg::KIND_ROT) begin
			if (rot.cw) begin
				ev = btn.level ? renc_pkg::EV_CW : renc_pkg::EV_CW_PRESSED;
			end else if (rot.ccw) begin
				ev = btn.level ? renc_pkg::EV_CCW : renc_pkg::EV_CCW_PRESSED;
			end
		end else if (btn.accept) begin
			pressed_next = !item_s1.level_sw;
			if (item_s1.level_sw && !rotated_q) begin
				ev = renc_pkg::EV_CLICK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			rotated_q   <= 1'b0;
		end else begin
			if (item.ready) begin
				valid_s1 <= item.valid;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			// A detent marks rotation; an accepted press clears the mark.
			if (rot_en && (rot.cw || rot.ccw)) begin
				rotated_q <= 1'b1;
			end else if (btn_en && btn.accept && !item_s1.level_sw) begin
				rotated_q <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.data;
		end
		if (adv) begin
			out_q.event_res      <= ev;
			out_q.button_pressed <= pressed_next;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

endmodule

### rtl/renc_rot.sv
// ----------------------------------------------------------------------------
// renc_rot: quadrature decoder
// Holds the AB history and the half-step accumulator.
// ----------------------------------------------------------------------------
module renc_rot (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                level_a,
	input  logic                level_b,
	output renc_pkg::rot_stat_t stat
);

	logic [1:0]          prev_ab_q;
	renc_pkg::step_t     step_count_q;
	logic [1:0]          ab;
	renc_pkg::step_t     step;
	logic signed [2:0]   sum;

	assign ab   = {level_a, level_b};
	assign step = renc_pkg::QUAD_STEP[{prev_ab_q, ab}];
	assign sum  = {step_count_q[1], step_count_q} + {step[1], step};

	// The accumulator only ever holds -1..1, so reaching +2 or -2 is a detent.
	assign stat.cw  = (sum == 3'sd2);
	assign stat.ccw = (sum == -3'sd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_ab_q    <= renc_pkg::AB_RESET;
			step_count_q <= 2'sd0;
		end else if (en) begin
			prev_ab_q <= ab;
			if (stat.cw || stat.ccw) begin
				step_count_q <= 2'sd0;
			end else begin
				step_count_q <= sum[1:0];
			end
		end
	end

endmodule

### rtl/renc_btn.sv
// ----------------------------------------------------------------------------
// renc_btn: switch debouncer
// Holds the debounced level, the last change time and the debounce interval.
// ----------------------------------------------------------------------------
module renc_btn (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  renc_pkg::debounce_t cfg_data,
	input  logic                en,
	input  logic                level_sw,
	input  renc_pkg::time_t     now_ms,
	output renc_pkg::btn_stat_t stat
);

	renc_pkg::debounce_t debounce_q;
	logic                switch_level_q;
	renc_pkg::time_t     last_change_q;
	renc_pkg::time_t     elapsed;

	// Unsigned difference handles the wrap of the millisecond counter.
	assign elapsed     = now_ms - last_change_q;
	assign stat.accept = (level_sw != switch_level_q) &&
		(elapsed > {{(renc_pkg::TIME_W - renc_pkg::DEBOUNCE_W){1'b0}}, debounce_q});
	assign stat.level  = switch_level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q     <= renc_pkg::DEBOUNCE_RESET;
			switch_level_q <= 1'b1;
			last_change_q  <= '0;
		end else begin
			if (cfg_we) begin
				debounce_q <= cfg_data;
			end
			if (en && stat.accept) begin
				switch_level_q <= level_sw;
				last_change_q  <= now_ms;
			end
		end
	end

endmodule

### tb/rotary_encoder_with_button_test.sv
// ----------------------------------------------------------------------------
// rotary_encoder_with_button_test: self-checking bench for the encoder block
// Sends pin-change events through the item channel and predicts each event
// result in a small tracker class. Results are compared field by field in
// arrival order. The debounce interval is rewritten between phases, and the
// phases draw on several mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module rotary_encoder_with_button_test;
	timeunit 1ns;
	timeprecision 1ps;

	import renc_pkg::*;

	// Cycles without any transaction on any channel before the run is called
	// hung. Even a 76 percent gap rate makes long runs of empty cycles rare,
	// so this leaves a wide margin.
	localparam int unsigned HANG_LIMIT   = 2000;
	// Settling at the end catches any result the block should not have produced.
	localparam int unsigned SETTLE_TICKS = 4;
	localparam int unsigned PHASE_ITEMS  = 240;

	// ------------------------------------------------------------------------
	// Event tracker: holds its own copy of the decoder state and the debounce
	// interval. It predicts one result per accepted pin event and checks the
	// results in order.
	// ------------------------------------------------------------------------
	class encoder_event_check;
		debounce_t         debounce;
		logic [1:0]        prev_ab;
		logic signed [2:0] half_steps;
		logic              sw_level;
		time_t             last_change;
		logic              rotated;
		result_t           events_due[$];
		int unsigned       mismatches;

		function new();
			debounce    = DEBOUNCE_RESET;
			prev_ab     = AB_RESET;
			half_steps  = 3'sd0;
			sw_level    = 1'b1;
			last_change = '0;
			rotated     = 1'b0;
			mismatches  = 0;
		endfunction

		// Step for an {old AB, new AB} transition. Transitions that move one
		// pin count +1 or -1; a repeated pair or a jump of both pins counts 0.
		function logic signed [2:0] quad_delta(logic [3:0] idx);
			case (idx)
				4'd2, 4'd4, 4'd11, 4'd13: return 3'sd1;
				4'd1, 4'd7, 4'd8, 4'd14:  return -3'sd1;
				default:                  return 3'sd0;
			endcase
		endfunction

		function void accept_pin_event(item_t it);
			result_t    r;
			logic [3:0] idx;
			time_t      elapsed;
			r.event_res = EV_NONE;
			if (it.kind == KIND_ROT) begin
				idx        = {prev_ab, it.level_a, it.level_b};
				prev_ab    = {it.level_a, it.level_b};
				half_steps = half_steps + quad_delta(idx);
				if (half_steps > 1) begin
					half_steps  = 3'sd0;
					rotated     = 1'b1;
					r.event_res = sw_level ? EV_CW : EV_CW_PRESSED;
				end else if (half_steps < -1) begin
					half_steps  = 3'sd0;
					rotated     = 1'b1;
					r.event_res = sw_level ? EV_CCW : EV_CCW_PRESSED;
				end
			end else begin
				elapsed = it.now_ms - last_change;
				if (it.level_sw != sw_level && elapsed > time_t'(debounce)) begin
					sw_level    = it.level_sw;
					last_change = it.now_ms;
					if (!it.level_sw)
						rotated = 1'b0;
					else if (!rotated)
						r.event_res = EV_CLICK;
				end
			end
			r.button_pressed = ~sw_level;
			events_due.push_back(r);
		endfunction

		function void compare_event(result_t got);
			result_t want;
			if (events_due.size() == 0) begin
				$display("%0t: result with none expected: event %0d pressed %0b",
					$time, got.event_res, got.button_pressed);
				mismatches++;
				return;
			end
			want = events_due.pop_front();
			if (got.event_res !== want.event_res) begin
				$display("%0t: event_res expected %0d actual %0d",
					$time, want.event_res, got.event_res);
				mismatches++;
			end
			if (got.button_pressed !== want.button_pressed) begin
				$display("%0t: button_pressed expected %0b actual %0b",
					$time, want.button_pressed, got.button_pressed);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	renc_chan_if #(.T(item_t))     item_ch ();
	renc_chan_if #(.T(debounce_t)) cfg_ch ();
	renc_chan_if #(.T(result_t))   result_ch ();

	rotary_encoder_with_button u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.cfg    (cfg_ch),
		.result (result_ch)
	);

	encoder_event_check chk;

	// Idle rates for the current phase, in percent of cycles.
	int unsigned sender_idle_pct;
	int unsigned stall_pct;
	int unsigned hang_count;
	// Direction of the simulated knob turn in the random part.
	bit          spin_cw;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Every input starts at a known value; reset is held low from the start and
	// released once, on a clock edge.
	initial begin
		arst_n          = 1'b0;
		item_ch.valid   = 1'b0;
		item_ch.data    = '0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.data     = '0;
		result_ch.ready = 1'b0;
		sender_idle_pct = 0;
		stall_pct       = 0;
		spin_cw         = 1'b1;
		chk             = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// The receiver stalls at random according to the current phase. With no
	// stall rate it is always ready.
	always @(posedge clk) begin
		if (!arst_n)
			result_ch.ready <= 1'b0;
		else
			result_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Every accepted result is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			chk.compare_event(result_ch.data);
	end

	// Watchdog: any transaction on any channel restarts the count.
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
			(result_ch.valid && result_ch.ready))
			hang_count <= 0;
		else
			hang_count <= hang_count + 1;
		if (hang_count >= HANG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, HANG_LIMIT);
			$display("TB_ERROR");
			$finish;
		end
	end

	initial hang_count = 0;

	// Next AB pair for one quarter turn in either direction. The
	// clockwise order is 11, 01, 00, 10.
	function automatic logic [1:0] cw_next(logic [1:0] ab);
		case (ab)
			2'b11:   return 2'b01;
			2'b01:   return 2'b00;
			2'b00:   return 2'b10;
			default: return 2'b11;
		endcase
	endfunction

	function automatic logic [1:0] ccw_next(logic [1:0] ab);
		case (ab)
			2'b11:   return 2'b10;
			2'b10:   return 2'b00;
			2'b00:   return 2'b01;
			default: return 2'b11;
		endcase
	endfunction

	function automatic item_t make_pin_event(logic kind, logic a, logic b, logic sw,
		time_t now);
		item_t it;
		it.kind     = kind;
		it.level_a  = a;
		it.level_b  = b;
		it.level_sw = sw;
		it.now_ms   = now;
		return it;
	endfunction

	// Random event built from the predicted state so that most of the
	// traffic is a plausible knob: turns that mostly keep one direction, and
	// button edges timed around the debounce boundary. The rest is noise:
	// repeated pairs, jumps of both pins, repeated switch levels and
	// arbitrary times.
	function automatic item_t random_pin_event();
		item_t       it;
		logic [1:0]  ab;
		int unsigned pick;
		time_t       db;
		time_t       gap;
		db = time_t'(chk.debounce);
		if ($urandom_range(99) < 50) begin
			if ($urandom_range(99) < 10)
				spin_cw = ~spin_cw;
			pick = $urandom_range(99);
			if (pick < 85)
				ab = spin_cw ? cw_next(chk.prev_ab) : ccw_next(chk.prev_ab);
			else if (pick < 92)
				ab = chk.prev_ab;
			else
				ab = 2'($urandom);
			it = make_pin_event(KIND_ROT, ab[1], ab[0], 1'($urandom), $urandom);
		end else begin
			case ($urandom_range(9))
				0, 1, 2: gap = $urandom_range(db);
				3:       gap = db;
				4:       gap = db + 1;
				8:       gap = $urandom;
				default: gap = db + 1 + $urandom_range(200);
			endcase
			it = make_pin_event(KIND_SW, 1'($urandom), 1'($urandom),
				($urandom_range(99) < 70) ? ~chk.sw_level : chk.sw_level,
				chk.last_change + gap);
		end
		return it;
	endfunction

	// Offers one item and returns at the edge that accepts it. Valid stays
	// high from the caller's edge onward, so back-to-back items keep it high.
	task automatic send_pin_event(item_t it);
		item_ch.valid <= 1'b1;
		item_ch.data  <= it;
		do @(posedge clk); while (!item_ch.ready);
		chk.accept_pin_event(it);
	endtask

	// Sender gap: zero or more empty cycles at the phase's idle rate.
	task automatic sender_gap();
		while ($urandom_range(99) < sender_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic wait_drain();
		while (chk.events_due.size() != 0)
			@(posedge clk);
	endtask

	// The debounce interval is only rewritten with no result outstanding.
	// Every item yields a result, so an empty prediction queue means idle.
	task automatic write_debounce(debounce_t value);
		wait_drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		chk.debounce = value;
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic run_random_phase(debounce_t value, int unsigned send_idle,
		int unsigned stall);
		write_debounce(value);
		sender_idle_pct = send_idle;
		stall_pct       = stall;
		for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
			sender_gap();
			send_pin_event(random_pin_event());
		end
		item_ch.valid <= 1'b0;
	endtask

	initial begin
		item_t directed_q[$];
		@(posedge arst_n);
		@(posedge clk);

		// Directed part under the reset debounce interval of 10 ms.
		// Rotation from the reset pair 11: a repeated pair counts nothing
		// and the switch level is ignored; two quarter turns one way report
		// clockwise, two the other way report counter-clockwise.
		directed_q.push_back(make_pin_event(KIND_ROT, 1, 1, 0, 32'h0000_0000));
		directed_q.push_back(make_pin_event(KIND_ROT, 0, 1, 0, 32'hFFFF_FFFF));
		directed_q.push_back(make_pin_event(KIND_ROT, 0, 0, 1, 32'h0000_0005));
		directed_q.push_back(make_pin_event(KIND_ROT, 0, 1, 1, 32'hA5A5_5A5A));
		directed_q.push_back(make_pin_event(KIND_ROT, 1, 1, 0, 32'h5A5A_A5A5));
		// Both pins jump at once: not a valid transition, no count.
		directed_q.push_back(make_pin_event(KIND_ROT, 0, 0, 1, 32'h0000_0000));
		// Press exactly at the debounce interval is too soon; one more ms is
		// accepted. The pins on a switch event must not disturb rotation.
		directed_q.push_back(make_pin_event(KIND_SW, 1, 1, 0, 32'd10));
		directed_q.push_back(make_pin_event(KIND_SW, 1, 0, 0, 32'd11));
		// Same level again is rejected regardless of time.
		directed_q.push_back(make_pin_event(KIND_SW, 0, 1, 0, 32'd100));
		// Release too soon, then in time with no rotation: a click.
		directed_q.push_back(make_pin_event(KIND_SW, 1, 1, 1, 32'd21));
		directed_q.push_back(make_pin_event(KIND_SW, 0, 0, 1, 32'd22));
		// Press near the top of the time range, then turn while pressed.
		directed_q.push_back(make_pin_event(KIND_SW, 1, 1, 0, 32'hFFFF_FFF0));
		directed_q.push_back(make_pin_event(KIND_ROT, 1, 0, 1, 32'd0));
		directed_q.push_back(make_pin_event(KIND_ROT, 1, 1, 1, 32'd0));
		directed_q.push_back(make_pin_event(KIND_ROT, 1, 0, 0, 32'd0));
		directed_q.push_back(make_pin_event(KIND_ROT, 0, 0, 0, 32'd0));
		// Release across the time wrap (21 ms elapsed) after rotation: no
		// click.
		directed_q.push_back(make_pin_event(KIND_SW, 0, 0, 1, 32'd5));
		// Press, a half turn that completes no step, release: still a click.
		directed_q.push_back(make_pin_event(KIND_SW, 0, 0, 0, 32'h20));
		directed_q.push_back(make_pin_event(KIND_ROT, 1, 0, 1, 32'd0));
		directed_q.push_back(make_pin_event(KIND_SW, 0, 0, 1, 32'h40));
		foreach (directed_q[i])
			send_pin_event(directed_q[i]);
		item_ch.valid <= 1'b0;

		// Random phases, each with its own debounce interval, including both ends
		// of the register's range, and one of several idle mixes.
		run_random_phase(16'd0, 0, 0);
		run_random_phase(16'hFFFF, 76, 0);
		run_random_phase(debounce_t'($urandom_range(2, 65534)), 0, 76);
		run_random_phase(16'd1, 22, 22);
		run_random_phase(debounce_t'($urandom_range(0, 300)), 76, 76);
		run_random_phase(DEBOUNCE_RESET, 0, 0);

		// Wait for every outstanding result, then settle to catch any
		// result the block should not have produced.
		wait_drain();
		repeat (SETTLE_TICKS) @(posedge clk);
		if (chk.mismatches == 0 && chk.events_due.size() == 0)
			$display("TB_OK");
		else begin
			if (chk.events_due.size() != 0)
				$display("%0t: %0d results never arrived", $time, chk.events_due.size());
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
